[hw/rtl/dpb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared widths, register indexes and the sideband type of the depth pixel
// back-projection pipeline.
// ----------------------------------------------------------------------------
package dpb_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int DEPTH_W = 16;               // depth sample, planar depth
    localparam int PIX_W   = 12;               // column / row index
    localparam int CP_W    = 16;               // principal point, Q12.4
    localparam int IF_W    = 24;               // reciprocal focal length, Q0.24
    localparam int XY_W    = 19;               // lateral outputs
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MAG_W  = 16;                // |col*16 - cx|
    localparam int OFS_W  = MAG_W + IF_W;      // |A|, Q.28
    localparam int AQ_W   = OFS_W - 11;        // |A| rounded to Q.16
    localparam int SQ_W   = 2 * AQ_W;          // Aq^2
    localparam int SW     = 60;                // ray term S, Q.32 (even)
    localparam int NS     = SW / 2;            // root bits, one per stage
    localparam int RW     = SW / 2;            // root width
    localparam int QB     = DEPTH_W + 1;       // quotient bits
    localparam int DW     = RW + QB;           // divider remainder width
    localparam int PROD_W = OFS_W + DEPTH_W;   // |A| * z
    localparam int MX_W   = PROD_W - 27;       // rounded lateral magnitude

    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECT_RAY   = 3'd4;

    typedef struct packed {
        logic               corr;
        logic [DEPTH_W-1:0] depth;
        logic [OFS_W-1:0]   ax;
        logic               nx;
        logic [OFS_W-1:0]   by;
        logic               ny;
    } side_t;

endpackage
`default_nettype wire

[hw/rtl/dpb_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_front
// Clamps the pixel index, forms the ray offsets |A|, |B| and their signs,
// and builds the ray term S = Aq^2 + Bq^2 + 2^32. Five register stages.
// ----------------------------------------------------------------------------
module dpb_front
    import dpb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [DEPTH_W-1:0] in_depth,
    input  wire logic [PIX_W-1:0]   in_col,
    input  wire logic [PIX_W-1:0]   in_row,
    input  wire logic [CP_W-1:0]    cx,
    input  wire logic [CP_W-1:0]    cy,
    input  wire logic [IF_W-1:0]    ifx,
    input  wire logic [IF_W-1:0]    ify,
    input  wire logic               corr,
    output logic                    out_valid,
    output logic [SW-1:0]           out_s,
    output side_t                   out_sb
);

    localparam logic [PIX_W:0]   W_LIM = (PIX_W+1)'(MAX_WIDTH);
    localparam logic [PIX_W:0]   H_LIM = (PIX_W+1)'(MAX_HEIGHT);
    localparam logic [PIX_W-1:0] W_TOP = PIX_W'(MAX_WIDTH - 1);
    localparam logic [PIX_W-1:0] H_TOP = PIX_W'(MAX_HEIGHT - 1);
    localparam logic [SW-1:0]    ONE_Q32 = SW'(1) << 32;

    logic [PIX_W-1:0] col_c, row_c;
    logic [CP_W-1:0]  pc, pr;
    logic [MAG_W-1:0] mx_next, my_next;
    logic             nx_next, ny_next;
    logic [OFS_W:0]   ra, rb;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [MAG_W-1:0]   mx1_reg, my1_reg;
    logic               nx1_reg, ny1_reg, c1_reg;
    logic [DEPTH_W-1:0] d1_reg;
    side_t              sb2_reg, sb3_reg, sb4_reg, sb5_reg;
    logic [AQ_W-1:0]    aq3_reg, bq3_reg;
    logic [SQ_W-1:0]    sa4_reg, sb4q_reg;
    logic [SW-1:0]      s5_reg;

    always_comb begin
        col_c = ({1'b0, in_col} >= W_LIM) ? W_TOP : in_col;
        row_c = ({1'b0, in_row} >= H_LIM) ? H_TOP : in_row;
        pc = {col_c, 4'b0000};
        pr = {row_c, 4'b0000};
        nx_next = pc < cx;
        ny_next = pr < cy;
        mx_next = nx_next ? (cx - pc) : (pc - cx);
        my_next = ny_next ? (cy - pr) : (pr - cy);
        ra = (OFS_W+1)'(sb2_reg.ax) + (OFS_W+1)'(2048);
        rb = (OFS_W+1)'(sb2_reg.by) + (OFS_W+1)'(2048);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx1_reg <= mx_next;
            my1_reg <= my_next;
            nx1_reg <= nx_next;
            ny1_reg <= ny_next;
            d1_reg  <= in_depth;
            c1_reg  <= corr;

            sb2_reg.corr  <= c1_reg;
            sb2_reg.depth <= d1_reg;
            sb2_reg.ax    <= OFS_W'(mx1_reg) * OFS_W'(ifx);
            sb2_reg.nx    <= nx1_reg;
            sb2_reg.by    <= OFS_W'(my1_reg) * OFS_W'(ify);
            sb2_reg.ny    <= ny1_reg;

            aq3_reg <= ra[OFS_W:12];
            bq3_reg <= rb[OFS_W:12];
            sb3_reg <= sb2_reg;

            sa4_reg  <= SQ_W'(aq3_reg) * SQ_W'(aq3_reg);
            sb4q_reg <= SQ_W'(bq3_reg) * SQ_W'(bq3_reg);
            sb4_reg  <= sb3_reg;

            s5_reg  <= SW'(sa4_reg) + SW'(sb4q_reg) + ONE_Q32;
            sb5_reg <= sb4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_s     = s5_reg;
    assign out_sb    = sb5_reg;

endmodule
`default_nettype wire

[hw/rtl/dpb_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module dpb_sqrt
    import dpb_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [SW-1:0] in_s,
    input  wire side_t         in_sb,
    output logic               out_valid,
    output logic [RW-1:0]      out_r,
    output side_t              out_sb
);

    logic          vld_reg [NS];
    logic [SW-1:0] v_reg   [NS];
    logic [SW-1:0] res_reg [NS];
    side_t         sb_reg  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
        logic          vld_i;
        logic [SW-1:0] v_i, r_i, trial, v_next, res_next;
        side_t         sb_i;

        if (k == 0) begin : g_first
            assign vld_i = in_valid;
            assign v_i   = in_s;
            assign r_i   = '0;
            assign sb_i  = in_sb;
        end else begin : g_rest
            assign vld_i = vld_reg[k-1];
            assign v_i   = v_reg[k-1];
            assign r_i   = res_reg[k-1];
            assign sb_i  = sb_reg[k-1];
        end

        always_comb begin
            trial = r_i + BIT;
            if (v_i >= trial) begin
                v_next   = v_i - trial;
                res_next = (r_i >> 1) + BIT;
            end else begin
                v_next   = v_i;
                res_next = r_i >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[k]   <= v_next;
                res_reg[k] <= res_next;
                sb_reg[k]  <= sb_i;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_r     = res_reg[NS-1][RW-1:0];
    assign out_sb    = sb_reg[NS-1];

    // S carries the +1 term, so the root is never below 1.0 in Q.16
    a_root_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_r >= RW'(65536)))
        else $error("ray length root below one");

endmodule
`default_nettype wire

[hw/rtl/dpb_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_div
// Rounded division z = (d*2^16 + r/2) / r: one setup stage, then a
// restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module dpb_div
    import dpb_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [RW-1:0] in_r,
    input  wire side_t         in_sb,
    output logic               out_valid,
    output logic [QB-1:0]      out_q,
    output side_t              out_sb
);

    logic          vld_reg [QB+1];
    logic [DW-1:0] rem_reg [QB+1];
    logic [RW-1:0] div_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    side_t         sb_reg  [QB+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'({in_sb.depth, 16'h0000}) + DW'(in_r >> 1);
            div_reg[0] <= in_r;
            q_reg[0]   <= '0;
            sb_reg[0]  <= in_sb;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        localparam int SH = QB - k;
        logic [DW-1:0] dsh, rem_next;
        logic          ge;

        always_comb begin
            dsh      = DW'(div_reg[k-1]) << SH;
            ge       = rem_reg[k-1] >= dsh;
            rem_next = ge ? (rem_reg[k-1] - dsh) : rem_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                div_reg[k] <= div_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                sb_reg[k]  <= sb_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign out_q     = q_reg[QB];
    assign out_sb    = sb_reg[QB];

    // the divisor is at least 1.0, so the quotient never exceeds the depth
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_q <= QB'(out_sb.depth)))
        else $error("quotient above input depth");

endmodule
`default_nettype wire

[hw/rtl/dpb_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dpb_scale
// Selects planar depth, scales the ray offsets by it and rounds and
// saturates x and y. Two register stages.
// ----------------------------------------------------------------------------
module dpb_scale
    import dpb_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [QB-1:0] in_q,
    input  wire side_t         in_sb,
    output logic               out_valid,
    output logic [DEPTH_W-1:0] out_z,
    output logic [XY_W-1:0]    out_x,
    output logic [XY_W-1:0]    out_y
);

    localparam logic [MX_W-1:0] POS_MAX = MX_W'(262143);
    localparam logic [MX_W-1:0] NEG_MAX = MX_W'(262144);

    function automatic logic [XY_W-1:0] sat_xy(input logic [MX_W-1:0] m,
                                               input logic neg);
        logic [MX_W-1:0] c;
        begin
            if (neg) begin
                c = (m > NEG_MAX) ? NEG_MAX : m;
                sat_xy = XY_W'(0) - c[XY_W-1:0];
            end else begin
                c = (m > POS_MAX) ? POS_MAX : m;
                sat_xy = c[XY_W-1:0];
            end
        end
    endfunction

    logic [DEPTH_W-1:0] z_sel;
    logic [PROD_W:0]    tx, ty;

    logic               v1_reg, v2_reg;
    logic [DEPTH_W-1:0] z1_reg, z2_reg;
    logic [PROD_W-1:0]  px1_reg, py1_reg;
    logic               nx1_reg, ny1_reg;
    logic [XY_W-1:0]    x2_reg, y2_reg;

    always_comb begin
        if (in_sb.corr) begin
            z_sel = in_q[QB-1] ? '1 : in_q[DEPTH_W-1:0];
        end else begin
            z_sel = in_sb.depth;
        end
        tx = (PROD_W+1)'(px1_reg) + ((PROD_W+1)'(1) << 27);
        ty = (PROD_W+1)'(py1_reg) + ((PROD_W+1)'(1) << 27);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg  <= z_sel;
            px1_reg <= PROD_W'(in_sb.ax) * PROD_W'(z_sel);
            py1_reg <= PROD_W'(in_sb.by) * PROD_W'(z_sel);
            nx1_reg <= in_sb.nx;
            ny1_reg <= in_sb.ny;

            z2_reg <= z1_reg;
            x2_reg <= sat_xy(tx[PROD_W:28], nx1_reg);
            y2_reg <= sat_xy(ty[PROD_W:28], ny1_reg);
        end
    end

    assign out_valid = v2_reg;
    assign out_z     = z2_reg;
    assign out_x     = x2_reg;
    assign out_y     = y2_reg;

    a_zero_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_z == '0) |-> (out_x == '0 && out_y == '0))
        else $error("nonzero lateral value at zero depth");

endmodule
`default_nettype wire

[hw/rtl/depth_pixel_backprojection.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// Back-projects a depth pixel through a pinhole camera to a 3-D point.
// ----------------------------------------------------------------------------
// Fully pipelined: one pixel enters every clock unless the output stalls,
// through 5 offset/ray-term stages, 30 square-root stages, 18 divider
// stages and 2 scaling stages. The whole pipeline advances together and
// holds while a finished point is not taken: s_ready = m_ready || !m_valid.
// The user must write camera registers on the cfg port, one register per
// transaction, only while no pixel is in flight; nothing enforces it.
module depth_pixel_backprojection
    import dpb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [DEPTH_W-1:0]    s_depth_in,
    input  wire logic [PIX_W-1:0]      s_pixel_col,
    input  wire logic [PIX_W-1:0]      s_pixel_row,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [DEPTH_W-1:0]         m_point_z,
    output logic signed [XY_W-1:0]     m_point_x,
    output logic signed [XY_W-1:0]     m_point_y
);

    logic [CP_W-1:0] cx_reg, cy_reg;
    logic [IF_W-1:0] ifx_reg, ify_reg;
    logic            corr_reg;
    logic            en;

    logic            f_valid, r_valid, q_valid;
    logic [SW-1:0]   f_s;
    logic [RW-1:0]   r_root;
    logic [QB-1:0]   q_quot;
    side_t           f_sb, r_sb, q_sb;
    logic [XY_W-1:0] x_raw, y_raw;

    assign cfg_ready = 1'b1;
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            ifx_reg  <= '0;
            ify_reg  <= '0;
            corr_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PRINCIPAL_X: cx_reg   <= cfg_data[CP_W-1:0];
                REG_PRINCIPAL_Y: cy_reg   <= cfg_data[CP_W-1:0];
                REG_INV_FOCAL_X: ifx_reg  <= cfg_data[IF_W-1:0];
                REG_INV_FOCAL_Y: ify_reg  <= cfg_data[IF_W-1:0];
                REG_CORRECT_RAY: corr_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    dpb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid && s_ready),
        .in_depth  (s_depth_in),
        .in_col    (s_pixel_col),
        .in_row    (s_pixel_row),
        .cx        (cx_reg),
        .cy        (cy_reg),
        .ifx       (ifx_reg),
        .ify       (ify_reg),
        .corr      (corr_reg),
        .out_valid (f_valid),
        .out_s     (f_s),
        .out_sb    (f_sb)
    );

    dpb_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_s      (f_s),
        .in_sb     (f_sb),
        .out_valid (r_valid),
        .out_r     (r_root),
        .out_sb    (r_sb)
    );

    dpb_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_r      (r_root),
        .in_sb     (r_sb),
        .out_valid (q_valid),
        .out_q     (q_quot),
        .out_sb    (q_sb)
    );

    dpb_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .in_q      (q_quot),
        .in_sb     (q_sb),
        .out_valid (m_valid),
        .out_z     (m_point_z),
        .out_x     (x_raw),
        .out_y     (y_raw)
    );

    assign m_point_x = signed'(x_raw);
    assign m_point_y = signed'(y_raw);

endmodule
`default_nettype wire
